// ===== hw/rtl/bfha_pkg.sv =====
// Package for the best-fit heap allocator.
// Holds the payload structs, request codes, controller states, datapath ops and status.
`timescale 1ns / 1ps

package bfha_pkg;

    localparam int HEAP_BYTES_DEF = 4096;

    localparam logic FN_ALLOC = 1'b0;
    localparam logic FN_FREE  = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] req_size;
        logic [11:0] free_addr;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [11:0] payload_addr;
    } t_res;

    typedef enum logic [4:0] {
        S_INIT0, S_INIT1, S_INIT2, S_IDLE,
        S_AWALK, S_ADEC, S_ASH, S_ASR, S_ASF, S_AFH, S_AFN,
        S_FWALK, S_FRN, S_FN, S_FRP, S_FP, S_FWH, S_FWF, S_FX,
        S_RESP
    } t_ctl_state;

    typedef enum logic [4:0] {
        DP_NOP, DP_INIT0, DP_INIT1, DP_INIT2, DP_LOAD,
        DP_AWALK, DP_ASH, DP_ASR, DP_ASF, DP_AFH, DP_AFN,
        DP_FWALK, DP_FRN, DP_FN, DP_FRP, DP_FP, DP_FWH, DP_FWF, DP_FX,
        DP_RESP
    } t_dp_op;

    typedef struct packed {
        logic in_func;
        logic in_addr_lo;
        logic sz0;
        logic nxt_end;
        logic found;
        logic split;
        logic anx_in;
        logic f_eq;
        logic f_busy;
        logic f_gt;
        logic fnx_in;
        logic prev_ok;
        logic fin_in;
        logic out_free;
    } t_dp_status;

endpackage

// ===== hw/rtl/best_fit_heap_allocator.sv =====
// Best-fit heap allocator over a fixed region: top level.
// Instantiates bfha_ctrl and bfha_dp; uses bfha_pkg.
//
// Input channel i_in_*: one request per transfer (func 0 allocate with
// req_size, func 1 free of free_addr). Output channel o_out_*: one result
// per request (ok, payload_addr), in request order.
// Allocate walks every block header, one header read per cycle, over all
// blocks in the heap (at most HEAP_BYTES/8), bound by the single read port
// of the heap memory. Free walks headers up to the target, then does the
// neighbor reads and header/footer writes, and then loads the result.
// One request is processed at a time; o_in_stall is high while busy.
// A finished result sits in the output register; the next request is taken
// while it waits, and processing holds before delivering its own result
// until the receiver drops i_out_stall.
// Reset formats the heap (one free block plus the end
// sentinel) with o_in_stall high; no result is pending after reset.
`timescale 1ns / 1ps

module best_fit_heap_allocator import bfha_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_res o_out_data
);

    t_dp_op     op;
    t_dp_status st;

    bfha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_st       (st),
        .o_op       (op),
        .o_in_stall (o_in_stall)
    );

    bfha_dp #(.HEAP_BYTES(HEAP_BYTES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (op),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_st        (st),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== hw/rtl/bfha_ctrl.sv =====
// Controller state machine for the best-fit heap allocator.
// Depends on bfha_pkg; drives datapath ops from datapath status.
`timescale 1ns / 1ps

module bfha_ctrl import bfha_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_st,
    output t_dp_op     o_op,
    output logic       o_in_stall
);

    t_ctl_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT0;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT0: n_state = S_INIT1;
            S_INIT1: n_state = S_INIT2;
            S_INIT2: n_state = S_IDLE;
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_st.in_func == FN_ALLOC) n_state = S_AWALK;
                    else if (i_st.in_addr_lo)     n_state = S_RESP;
                    else                          n_state = S_FWALK;
                end
            end
            S_AWALK: if (i_st.sz0 || i_st.nxt_end) n_state = S_ADEC;
            S_ADEC: begin
                if (!i_st.found)     n_state = S_RESP;
                else if (i_st.split) n_state = S_ASH;
                else                 n_state = S_AFH;
            end
            S_ASH: n_state = S_ASR;
            S_ASR: n_state = S_ASF;
            S_ASF: n_state = S_RESP;
            S_AFH: n_state = i_st.anx_in ? S_AFN : S_RESP;
            S_AFN: n_state = S_RESP;
            S_FWALK: begin
                if (i_st.sz0)          n_state = S_RESP;
                else if (i_st.f_eq)    n_state = i_st.f_busy ? S_FRN : S_RESP;
                else if (i_st.f_gt)    n_state = S_RESP;
                else if (i_st.nxt_end) n_state = S_RESP;
            end
            S_FRN: n_state = i_st.fnx_in ? S_FN : S_FRP;
            S_FN:  n_state = S_FRP;
            S_FRP: n_state = i_st.prev_ok ? S_FP : S_FWH;
            S_FP:  n_state = S_FWH;
            S_FWH: n_state = S_FWF;
            S_FWF: n_state = i_st.fin_in ? S_FX : S_RESP;
            S_FX:  n_state = S_RESP;
            S_RESP: if (i_st.out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_op = DP_NOP;
        case (r_state)
            S_INIT0: o_op = DP_INIT0;
            S_INIT1: o_op = DP_INIT1;
            S_INIT2: o_op = DP_INIT2;
            S_IDLE:  o_op = i_in_valid ? DP_LOAD : DP_NOP;
            S_AWALK: o_op = DP_AWALK;
            S_ASH:   o_op = DP_ASH;
            S_ASR:   o_op = DP_ASR;
            S_ASF:   o_op = DP_ASF;
            S_AFH:   o_op = DP_AFH;
            S_AFN:   o_op = DP_AFN;
            S_FWALK: o_op = DP_FWALK;
            S_FRN:   o_op = DP_FRN;
            S_FN:    o_op = DP_FN;
            S_FRP:   o_op = DP_FRP;
            S_FP:    o_op = DP_FP;
            S_FWH:   o_op = DP_FWH;
            S_FWF:   o_op = DP_FWF;
            S_FX:    o_op = DP_FX;
            S_RESP:  o_op = i_st.out_free ? DP_RESP : DP_NOP;
            default: o_op = DP_NOP;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== hw/rtl/bfha_dp.sv =====
// Datapath of the best-fit heap allocator: heap word memory, walk
// registers, split/coalesce arithmetic and the result register. Uses bfha_pkg.
`timescale 1ns / 1ps

module bfha_dp import bfha_pkg::*; #(
    parameter int HEAP_BYTES = HEAP_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_op     i_op,
    input  t_req       i_in_data,
    input  logic       i_out_stall,
    output t_dp_status o_st,
    output logic       o_out_valid,
    output t_res       o_out_data
);

    localparam int PW      = $clog2(HEAP_BYTES) + 1;
    localparam int CW      = (PW > 17) ? PW : 17;
    localparam int DW      = PW;
    localparam int WORDS   = HEAP_BYTES / 4;
    localparam int AW      = $clog2(WORDS);
    localparam logic [CW-1:0] END_POS = CW'(HEAP_BYTES - 4);
    localparam logic [CW-1:0] SZ_MASK = ~CW'(7);

    logic [DW-1:0] r_mem [WORDS];
    logic [DW-1:0] r_rdata, r_h;
    logic [CW-1:0] r_pos, r_need, r_target, r_best, r_bsz, r_sz, r_start;
    logic          r_bp, r_found, r_ok, r_ovalid;
    logic [11:0]   r_paddr;
    t_res          r_out;

    logic [CW-1:0] rsz, hsz, nxt, anx, fnx, fin, rd_addr, wr_addr;
    logic [DW-1:0] wr_data;
    logic          wr_en, wr_go, cand, out_free;

    assign rsz = CW'(r_rdata) & SZ_MASK;
    assign hsz = CW'(r_h) & SZ_MASK;
    assign nxt = r_pos + rsz;
    assign anx = r_best + r_bsz;
    assign fnx = r_target + hsz;
    assign fin = r_start + r_sz;
    assign cand = !r_rdata[0] && (rsz >= r_need) && (!r_found || rsz < r_bsz);
    assign out_free = !r_ovalid || !i_out_stall;

    always_comb begin
        rd_addr = r_pos;
        wr_en   = 1'b0;
        wr_addr = r_pos;
        wr_data = r_rdata;
        case (i_op)
            DP_INIT0: begin
                wr_en = 1'b1; wr_addr = CW'(4);
                wr_data = DW'(HEAP_BYTES - 8) | DW'(2);
            end
            DP_INIT1: begin
                wr_en = 1'b1; wr_addr = CW'(HEAP_BYTES - 12);
                wr_data = DW'(HEAP_BYTES - 8);
            end
            DP_INIT2: begin
                wr_en = 1'b1; wr_addr = END_POS; wr_data = DW'(1);
            end
            DP_LOAD:  rd_addr = CW'(4);
            DP_AWALK, DP_FWALK: rd_addr = nxt;
            DP_ASH: begin
                wr_en = 1'b1; wr_addr = r_best;
                wr_data = DW'(r_need) | DW'({r_bp, 1'b1});
            end
            DP_ASR: begin
                wr_en = 1'b1; wr_addr = r_best + r_need;
                wr_data = DW'(r_bsz - r_need) | DW'(2);
            end
            DP_ASF: begin
                wr_en = 1'b1; wr_addr = anx - CW'(4);
                wr_data = DW'(r_bsz - r_need);
            end
            DP_AFH: begin
                wr_en = 1'b1; wr_addr = r_best;
                wr_data = DW'(r_bsz) | DW'({r_bp, 1'b1});
                rd_addr = anx;
            end
            DP_AFN: begin
                wr_en = 1'b1; wr_addr = anx; wr_data = r_rdata | DW'(2);
            end
            DP_FRN: rd_addr = fnx;
            DP_FRP: rd_addr = r_target - CW'(4);
            DP_FWH: begin
                wr_en = 1'b1; wr_addr = r_start; wr_data = DW'(r_sz) | DW'(2);
            end
            DP_FWF: begin
                wr_en = 1'b1; wr_addr = fin - CW'(4); wr_data = DW'(r_sz);
                rd_addr = fin;
            end
            DP_FX: begin
                wr_en = 1'b1; wr_addr = fin; wr_data = r_rdata & ~DW'(2);
            end
            default: ;
        endcase
    end

    // the sentinel word is written only while formatting the heap
    assign wr_go = wr_en && ((i_op == DP_INIT2) || (wr_addr != END_POS));

    always_ff @(posedge i_clk) begin
        if (wr_go) r_mem[wr_addr[AW+1:2]] <= wr_data;
        r_rdata <= r_mem[rd_addr[AW+1:2]];
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            DP_LOAD: begin
                r_pos    <= CW'(4);
                r_found  <= 1'b0;
                r_ok     <= 1'b0;
                r_paddr  <= '0;
                r_need   <= (CW'(i_in_data.req_size) + CW'(11)) & SZ_MASK;
                r_target <= CW'(i_in_data.free_addr) - CW'(4);
            end
            DP_AWALK: begin
                if (cand) begin
                    r_found <= 1'b1;
                    r_best  <= r_pos;
                    r_bsz   <= rsz;
                    r_bp    <= r_rdata[1];
                end
                r_pos <= nxt;
            end
            DP_FWALK: begin
                r_h   <= r_rdata;
                r_pos <= nxt;
            end
            DP_ASH, DP_AFH: begin
                r_ok    <= 1'b1;
                r_paddr <= r_best[11:0] + 12'd4;
            end
            DP_FRN: begin
                r_sz    <= hsz;
                r_start <= r_target;
            end
            DP_FN: if (!r_rdata[0]) r_sz <= r_sz + rsz;
            DP_FP: begin
                if (rsz != '0 && rsz <= r_target - CW'(4)) begin
                    r_start <= r_target - rsz;
                    r_sz    <= r_sz + rsz;
                end
            end
            DP_FWH: r_ok <= 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_op == DP_RESP) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_RESP) r_out <= '{ok: r_ok, payload_addr: r_paddr};
    end

    always_comb begin
        o_st.in_func    = i_in_data.func;
        o_st.in_addr_lo = (i_in_data.free_addr < 12'd4);
        o_st.sz0        = (rsz == '0);
        o_st.nxt_end    = (nxt >= END_POS);
        o_st.found      = r_found;
        o_st.split      = (r_bsz >= r_need + CW'(8));
        o_st.anx_in     = (anx < END_POS);
        o_st.f_eq       = (r_pos == r_target);
        o_st.f_busy     = r_rdata[0];
        o_st.f_gt       = (r_pos > r_target);
        o_st.fnx_in     = (fnx < END_POS);
        o_st.prev_ok    = !r_h[1] && (r_target >= CW'(8));
        o_st.fin_in     = (fin < END_POS);
        o_st.out_free   = out_free;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_sentinel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && wr_addr == END_POS) |-> (i_op == DP_INIT2))
        else $error("heap write aimed at end sentinel");
    a_resp_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_RESP) |-> out_free)
        else $error("result loaded over an untaken result");
    a_walk_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == DP_AWALK || i_op == DP_FWALK) |-> (r_pos[2:0] == 3'd4))
        else $error("block walk off header alignment");
`endif

endmodule

// ===== tb/tb_best_fit_heap_allocator.sv =====
// Testbench for best_fit_heap_allocator: directed table then random alloc/free traffic.
// Predicts each result with a local heap model; depends on bfha_pkg and the RTL.
`timescale 1ns / 1ps

module tb_best_fit_heap_allocator;
    import bfha_pkg::*;

    localparam int HB = HEAP_BYTES_DEF;
    localparam int NW = HB / 4;
    localparam int ENDP = HB - 4;

    logic i_clk, i_rst_n, i_in_valid, i_out_stall;
    logic o_in_stall, o_out_valid;
    t_req i_in_data;
    t_res o_out_data;

    best_fit_heap_allocator dut (.*);

    typedef struct {
        t_req rq;
        logic chk;
        t_res want;
    } t_row;

    logic [31:0] heap[NW];
    t_res expected_res[$];
    int live_addrs[$];
    int n_err;
    bit out_idle_on;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("** best_fit_heap_allocator: FAILED **");
        $finish;
    end

    function automatic logic [31:0] hrd(int p);
        return (p >= 0 && (p >> 2) < NW) ? heap[p >> 2] : 32'd0;
    endfunction

    function automatic void hwr(int p, logic [31:0] v);
        if ((p >> 2) < NW && p != ENDP) heap[p >> 2] = v;
    endfunction

    function automatic void heap_format();
        foreach (heap[i]) heap[i] = 0;
        heap[1] = (HB - 8) | 2;
        heap[(HB - 12) >> 2] = HB - 8;
        heap[ENDP >> 2] = 1;
    endfunction

    function automatic t_res heap_apply(t_req rq);
        t_res r;
        int pos, best, bsz, need, sz, rem, tgt, st, nx, psz;
        logic [31:0] h, nh;
        bit found, hit;
        r = '0;
        pos = 4; found = 0; best = 0; bsz = 0;
        if (rq.func == FN_ALLOC) begin
            need = int'(rq.req_size) + 4;
            if (need < 8) need = 8;
            need = (need + 7) & ~7;
            while (pos < ENDP) begin
                h = hrd(pos); sz = h & ~32'd7;
                if (sz == 0) break;
                if (!h[0] && sz >= need && (!found || sz < bsz)) begin
                    found = 1; best = pos; bsz = sz;
                end
                pos += sz;
            end
            if (!found) return r;
            h = hrd(best); rem = bsz - need;
            if (rem >= 8) begin
                hwr(best, need | (h & 2) | 1);
                hwr(best + need, rem | 2);
                hwr(best + bsz - 4, rem);
            end else begin
                nx = best + bsz;
                hwr(best, bsz | (h & 2) | 1);
                if (nx < ENDP) hwr(nx, hrd(nx) | 2);
            end
            r.ok = 1; r.payload_addr = 12'(best + 4);
            return r;
        end
        if (rq.free_addr < 4) return r;
        tgt = int'(rq.free_addr) - 4; hit = 0;
        while (pos < ENDP) begin
            h = hrd(pos); sz = h & ~32'd7;
            if (sz == 0) break;
            if (pos == tgt) begin hit = h[0]; break; end
            if (pos > tgt) break;
            pos += sz;
        end
        if (!hit) return r;
        h = hrd(tgt); st = tgt; sz = h & ~32'd7; nx = tgt + sz;
        nh = hrd(nx);
        if (nx < ENDP && !nh[0]) sz += nh & ~32'd7;
        if (!h[1] && tgt >= 8) begin
            psz = hrd(tgt - 4) & ~32'd7;
            if (psz != 0 && psz <= tgt - 4) begin st = tgt - psz; sz += psz; end
        end
        hwr(st, sz | 2);
        hwr(st + sz - 4, sz);
        nx = st + sz;
        if (nx < ENDP) hwr(nx, hrd(nx) & ~32'd2);
        r.ok = 1;
        return r;
    endfunction

    // Output side: random stall bursts while out_idle_on is set, checking on each transfer.
    initial begin
        int burst;
        t_res w;
        i_out_stall = 1;
        burst = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                if (expected_res.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result ok=%0d addr=%0d",
                                              o_out_data.ok, o_out_data.payload_addr);
                end else begin
                    w = expected_res.pop_front();
                    if (w.ok !== o_out_data.ok ||
                        w.payload_addr !== o_out_data.payload_addr) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: exp ok=%0d addr=%0d got ok=%0d addr=%0d",
                                     w.ok, w.payload_addr, o_out_data.ok,
                                     o_out_data.payload_addr);
                    end
                end
            end
            if (burst > 0) burst--;
            else if (out_idle_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 9);
            i_out_stall <= (burst > 0);
        end
    end

    task automatic send_req(t_req rq, logic chk, t_res want);
        t_res p;
        int gap;
        if (out_idle_on && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 9);
            i_in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1;
        i_in_data <= rq;
        @(posedge i_clk iff !o_in_stall);
        p = heap_apply(rq);
        if (chk && (p.ok !== want.ok || p.payload_addr !== want.payload_addr)) begin
            p = want;
        end
        expected_res.push_back(p);
        if (rq.func == FN_ALLOC && p.ok) live_addrs.push_back(p.payload_addr);
        if (rq.func == FN_FREE && p.ok)
            foreach (live_addrs[i]) if (live_addrs[i] == rq.free_addr) begin
                live_addrs.delete(i); break;
            end
    endtask

    function automatic t_req mk(logic f, int sz, int a);
        t_req r;
        r.func = f; r.req_size = 16'(sz); r.free_addr = 12'(a);
        return r;
    endfunction

    initial begin
        t_row rows[$];
        t_req rq;
        int k;
        n_err = 0;
        out_idle_on = 1;
        i_rst_n = 0; i_in_valid = 0; i_in_data = '0;
        heap_format();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        rows.push_back('{mk(FN_ALLOC, 0, 4095), 1, '{1'b1, 12'd8}});
        rows.push_back('{mk(FN_ALLOC, 65535, 0), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_ALLOC, HB - 12, 0), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_ALLOC, 4, 0), 1, '{1'b1, 12'd16}});
        rows.push_back('{mk(FN_ALLOC, 5, 0), 1, '{1'b1, 12'd24}});
        rows.push_back('{mk(FN_ALLOC, 100, 0), 0, '0});
        rows.push_back('{mk(FN_FREE, 65535, 0), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 2), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 4095), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 12), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 20), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 16), 1, '{1'b1, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 16), 1, '{1'b0, 12'd0}});
        rows.push_back('{mk(FN_FREE, 0, 8), 0, '0});
        rows.push_back('{mk(FN_ALLOC, 8, 0), 0, '0});
        rows.push_back('{mk(FN_FREE, 0, 24), 0, '0});
        rows.push_back('{mk(FN_ALLOC, HB - 600, 0), 0, '0});
        rows.push_back('{mk(FN_ALLOC, 0, 0), 0, '0});
        rows.push_back('{mk(FN_FREE, 0, 4088), 1, '{1'b0, 12'd0}});
        foreach (rows[i]) send_req(rows[i].rq, rows[i].chk, rows[i].want);
        while (live_addrs.size() > 0) send_req(mk(FN_FREE, $urandom, live_addrs[0]), 0, '0);

        for (int n = 0; n < 400; n++) begin
            if (n == 340) out_idle_on = 0;
            k = $urandom_range(0, 99);
            if (k < 45) begin
                rq = mk(FN_ALLOC, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1200)
                        : $urandom_range(0, 120), $urandom);
                if ($urandom_range(0, 30) == 0) rq.req_size = 16'($urandom);
            end else if (k < 85 && live_addrs.size() > 0)
                rq = mk(FN_FREE, $urandom,
                        live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
            else if (k < 92)
                rq = mk(FN_FREE, $urandom, $urandom);
            else
                rq = mk(FN_FREE, $urandom, ($urandom_range(1, 511) * 8) & 12'hff8);
            send_req(rq, 0, '0);
        end
        i_in_valid <= 0;

        k = 0;
        while (expected_res.size() > 0 && k < 100000) begin
            @(posedge i_clk);
            k++;
        end
        repeat (50) @(posedge i_clk);
        if (n_err == 0 && expected_res.size() == 0) begin
            $display("** best_fit_heap_allocator: PASSED **");
        end else begin
            $display("** best_fit_heap_allocator: FAILED **");
        end
        $finish;
    end
endmodule
